### rtl/amt_pkg.sv
// ----------------------------------------------------------------------------
// Alarm match table package
// Shared types and codes for the alarm match table: command codes, the
// stored entry layout, the input word layout and the sequencer states.
// ----------------------------------------------------------------------------
package amt_pkg;

  // Command codes carried in the cmd field of an input word.
  typedef enum logic [2:0] {
    CMD_ADD     = 3'd0,
    CMD_DELETE  = 3'd1,
    CMD_ENABLE  = 3'd2,
    CMD_DISABLE = 3'd3,
    CMD_UPDATE  = 3'd4,
    CMD_CHECK   = 3'd5
  } cmd_e;

  // Result status codes.
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  // One stored alarm entry.
  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       enabled;
    logic       repeating;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // One input word as held while the sequencer works on it.
  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] entry_index;
    logic [4:0] time_hour;
    logic [5:0] time_minute;
    logic [5:0] time_second;
    logic       entry_enabled;
    logic       entry_repeat;
  } in_item_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_RMW_WR,
    ST_CHK_RD,
    ST_CHK_CMP,
    ST_DONE
  } state_e;

endpackage

### rtl/amt_if.sv
// ----------------------------------------------------------------------------
// Alarm match table stream interfaces
// Valid/ready channels for command words into the table and result words
// out of it. A word moves at a rising edge where valid and ready are high.
// ----------------------------------------------------------------------------

// Command channel.
interface amt_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] entry_index;
  logic [4:0] time_hour;
  logic [5:0] time_minute;
  logic [5:0] time_second;
  logic       entry_enabled;
  logic       entry_repeat;

  modport source (
    output valid, cmd, entry_index, time_hour, time_minute, time_second,
           entry_enabled, entry_repeat,
    input  ready
  );

  modport sink (
    input  valid, cmd, entry_index, time_hour, time_minute, time_second,
           entry_enabled, entry_repeat,
    output ready
  );
endinterface

// Result channel.
interface amt_out_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic       hit;
  logic [3:0] hit_index;
  logic [4:0] entry_count;

  modport source (
    output valid, status, hit, hit_index, entry_count,
    input  ready
  );

  modport sink (
    input  valid, status, hit, hit_index, entry_count,
    output ready
  );
endinterface

### rtl/amt_ram.sv
// ----------------------------------------------------------------------------
// Alarm match table RAM
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module amt_ram #(
  parameter int unsigned WIDTH = 19,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/alarm_match_table.sv
// ----------------------------------------------------------------------------
// Alarm match table
// Compacted table of alarm entries with add, delete, enable, disable, update
// and check commands, run by a small sequencer over one entry RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Command words enter on in_i (valid/ready) and every command returns one
//   result word on out_o (valid/ready). One command is worked on at a time;
//   in_i.ready is high only while the sequencer is idle.
//   Steps per command, with one entry RAM whose single read port has
//   registered data: add and update write the RAM in the decode state;
//   rejected commands go straight to the result; enable and disable read
//   the entry in decode and write it back; delete reads and writes each
//   entry above the deleted index to shift it down; check reads and
//   compares from index 0 until a hit or the end of the table.
//   Each entry touched costs one RAM read and one compare or write; the
//   next word can be taken in the cycle after the result is loaded.
//   The result sits in an output register; while the receiver stalls, a new
//   command may still be accepted and run, and it waits for the register
//   before finishing. Reset empties the table (the count goes to zero) and
//   drops any pending result; the RAM is not cleared.
// ----------------------------------------------------------------------------
module alarm_match_table #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  amt_in_if.sink    in_i,
  amt_out_if.source out_o
);

  localparam int unsigned IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW   = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMPW = CW + 8;

  amt_pkg::state_e   state_q, state_d;
  amt_pkg::in_item_t item_q, item_d;
  logic [CW-1:0]     ptr_q, ptr_d;
  logic [CW-1:0]     count_q, count_d;
  logic              status_q, status_d;
  logic              hit_q, hit_d;

  logic              out_valid_q, out_valid_d;
  logic              out_status_q;
  logic              out_hit_q;
  logic [3:0]        out_hit_index_q;
  logic [4:0]        out_count_q;

  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  amt_pkg::entry_t   ram_wdata;
  logic [IW-1:0]     ram_raddr;
  amt_pkg::entry_t   ram_rdata;

  logic              in_fire;
  logic              out_load;
  logic              full;
  logic              idx_ok;
  logic [CW-1:0]     ptr_inc;
  logic              shift_more;
  logic              scan_more;
  logic              match;
  logic [CMPW-1:0]   idx_ext;
  logic [CMPW-1:0]   count_ext;
  amt_pkg::entry_t   new_entry;
  amt_pkg::cmd_e     cmd;

  // Entry storage.
  amt_ram #(
    .WIDTH (amt_pkg::ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Handshakes.
  assign in_i.ready = (state_q == amt_pkg::ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_load   = (state_q == amt_pkg::ST_DONE) && (!out_valid_q || out_o.ready);

  // Shared compare and increment unit for the sequencer.
  assign cmd        = amt_pkg::cmd_e'(item_q.cmd);
  assign idx_ext    = CMPW'(item_q.entry_index);
  assign count_ext  = CMPW'(count_q);
  assign idx_ok     = idx_ext < count_ext;
  assign full       = (count_q == CW'(MAX_ENTRIES));
  assign ptr_inc    = ptr_q + CW'(1);
  assign shift_more = ptr_inc < count_q;
  assign scan_more  = ptr_q < count_q;
  assign match      = ram_rdata.enabled &&
                      (ram_rdata.hour == item_q.time_hour) &&
                      (ram_rdata.minute == item_q.time_minute) &&
                      (ram_rdata.second == item_q.time_second);

  assign new_entry.hour      = item_q.time_hour;
  assign new_entry.minute    = item_q.time_minute;
  assign new_entry.second    = item_q.time_second;
  assign new_entry.enabled   = item_q.entry_enabled;
  assign new_entry.repeating = item_q.entry_repeat;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      amt_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = amt_pkg::ST_DECODE;
        end
      end
      amt_pkg::ST_DECODE: begin
        case (cmd)
          amt_pkg::CMD_DELETE: begin
            state_d = idx_ok ? amt_pkg::ST_DEL_RD : amt_pkg::ST_DONE;
          end
          amt_pkg::CMD_ENABLE,
          amt_pkg::CMD_DISABLE: begin
            state_d = idx_ok ? amt_pkg::ST_RMW_WR : amt_pkg::ST_DONE;
          end
          amt_pkg::CMD_CHECK: begin
            state_d = amt_pkg::ST_CHK_RD;
          end
          default: begin
            state_d = amt_pkg::ST_DONE;
          end
        endcase
      end
      amt_pkg::ST_DEL_RD: begin
        state_d = shift_more ? amt_pkg::ST_DEL_WR : amt_pkg::ST_DONE;
      end
      amt_pkg::ST_DEL_WR: begin
        state_d = amt_pkg::ST_DEL_RD;
      end
      amt_pkg::ST_RMW_WR: begin
        state_d = amt_pkg::ST_DONE;
      end
      amt_pkg::ST_CHK_RD: begin
        state_d = scan_more ? amt_pkg::ST_CHK_CMP : amt_pkg::ST_DONE;
      end
      amt_pkg::ST_CHK_CMP: begin
        state_d = match ? amt_pkg::ST_DONE : amt_pkg::ST_CHK_RD;
      end
      amt_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = amt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = amt_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath control: RAM ports, pointer, count and working result.
  always_comb begin
    item_d    = item_q;
    ptr_d     = ptr_q;
    count_d   = count_q;
    status_d  = status_q;
    hit_d     = hit_q;
    ram_we    = 1'b0;
    ram_waddr = ptr_q[IW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = ptr_q[IW-1:0];
    case (state_q)
      amt_pkg::ST_IDLE: begin
        if (in_fire) begin
          item_d.cmd           = in_i.cmd;
          item_d.entry_index   = in_i.entry_index;
          item_d.time_hour     = in_i.time_hour;
          item_d.time_minute   = in_i.time_minute;
          item_d.time_second   = in_i.time_second;
          item_d.entry_enabled = in_i.entry_enabled;
          item_d.entry_repeat  = in_i.entry_repeat;
          status_d             = amt_pkg::STATUS_OK;
          hit_d                = 1'b0;
        end
      end
      amt_pkg::ST_DECODE: begin
        case (cmd)
          amt_pkg::CMD_ADD: begin
            if (full) begin
              status_d = amt_pkg::STATUS_REJECT;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = count_q[IW-1:0];
              ram_wdata = new_entry;
              count_d   = count_q + CW'(1);
            end
          end
          amt_pkg::CMD_DELETE: begin
            if (!idx_ok) begin
              status_d = amt_pkg::STATUS_REJECT;
            end else begin
              ptr_d = CW'(item_q.entry_index);
            end
          end
          amt_pkg::CMD_ENABLE,
          amt_pkg::CMD_DISABLE: begin
            if (!idx_ok) begin
              status_d = amt_pkg::STATUS_REJECT;
            end else begin
              ram_raddr = IW'(item_q.entry_index);
              ptr_d     = CW'(item_q.entry_index);
            end
          end
          amt_pkg::CMD_UPDATE: begin
            if (!idx_ok) begin
              status_d = amt_pkg::STATUS_REJECT;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = IW'(item_q.entry_index);
              ram_wdata = new_entry;
            end
          end
          amt_pkg::CMD_CHECK: begin
            ptr_d = '0;
          end
          default: begin
            status_d = amt_pkg::STATUS_REJECT;
          end
        endcase
      end
      amt_pkg::ST_DEL_RD: begin
        // Fetch the next entry down, or close the table at the end.
        if (shift_more) begin
          ram_raddr = ptr_inc[IW-1:0];
        end else begin
          count_d = count_q - CW'(1);
        end
      end
      amt_pkg::ST_DEL_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        ptr_d     = ptr_inc;
      end
      amt_pkg::ST_RMW_WR: begin
        ram_we            = 1'b1;
        ram_wdata         = ram_rdata;
        ram_wdata.enabled = (cmd == amt_pkg::CMD_ENABLE);
      end
      amt_pkg::ST_CHK_RD: begin
        ram_raddr = ptr_q[IW-1:0];
      end
      amt_pkg::ST_CHK_CMP: begin
        // A single shot alarm disarms itself on a hit.
        if (match) begin
          hit_d = 1'b1;
          if (!ram_rdata.repeating) begin
            ram_we            = 1'b1;
            ram_wdata         = ram_rdata;
            ram_wdata.enabled = 1'b0;
          end
        end else begin
          ptr_d = ptr_inc;
        end
      end
      default: begin
      end
    endcase
  end

  // Result register valid.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= amt_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    ptr_q    <= ptr_d;
    status_q <= status_d;
    hit_q    <= hit_d;
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q    <= status_q;
      out_hit_q       <= hit_q;
      out_hit_index_q <= hit_q ? 4'(ptr_q) : 4'd0;
      out_count_q     <= 5'(count_q);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.hit         = out_hit_q;
  assign out_o.hit_index   = out_hit_index_q;
  assign out_o.entry_count = out_count_q;

endmodule
